// ===== rtl/core/lsam_pkg.sv =====
package lsam_pkg;

   // Default coordinate width; the top level takes it as a parameter
   localparam int LSAM_COORD_BITS = 16;

   // Fixed field widths of the stream and register ports
   localparam int FIELD_BITS  = 16;
   localparam int SPEED_BITS  = 8;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Request kinds carried in req_tuser
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_DISPATCH = 2'd1;
   localparam logic [1:0] REQ_RETURN   = 2'd2;

   // Register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_X = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_Y = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_ENROUTE   = 2'd1,
      ST_ONSCENE   = 2'd2,
      ST_RETURNING = 2'd3
   } agent_status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_WALK,
      SEQ_FINISH
   } seq_state_type;

   // Flags from the line setup unit
   typedef struct packed {
      logic same_pos;
      logic dir_x_neg;
      logic dir_y_neg;
   } setup_flags_type;

   // Flags from the step unit
   typedef struct packed {
      logic at_goal;
      logic take_x;
      logic take_y;
   } step_flags_type;

endpackage

// ===== rtl/core/lsam_line_setup.sv =====
module lsam_line_setup
   import lsam_pkg::*;
#(
   parameter int COORD_BITS = LSAM_COORD_BITS
) (
   input  logic signed [COORD_BITS-1:0] cur_x,
   input  logic signed [COORD_BITS-1:0] cur_y,
   input  logic signed [COORD_BITS-1:0] target_x,
   input  logic signed [COORD_BITS-1:0] target_y,
   output logic        [COORD_BITS:0]   span_x,
   output logic        [COORD_BITS:0]   span_y,
   output logic signed [COORD_BITS+2:0] line_error,
   output setup_flags_type              flags
);

   localparam int SW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 3;

   logic signed [SW-1:0] diff_x;
   logic signed [SW-1:0] diff_y;

   // Signed differences one bit wider, then magnitude
   assign diff_x = SW'(target_x) - SW'(cur_x);
   assign diff_y = SW'(target_y) - SW'(cur_y);
   assign span_x = diff_x[SW-1] ? SW'(-diff_x) : SW'(diff_x);
   assign span_y = diff_y[SW-1] ? SW'(-diff_y) : SW'(diff_y);

   assign line_error = $signed(EW'(span_x)) - $signed(EW'(span_y));

   assign flags.same_pos  = (cur_x == target_x) && (cur_y == target_y);
   assign flags.dir_x_neg = !(cur_x < target_x);
   assign flags.dir_y_neg = !(cur_y < target_y);

endmodule

// ===== rtl/core/lsam_step_unit.sv =====
module lsam_step_unit
   import lsam_pkg::*;
#(
   parameter int COORD_BITS = LSAM_COORD_BITS
) (
   input  logic signed [COORD_BITS-1:0] cur_x,
   input  logic signed [COORD_BITS-1:0] cur_y,
   input  logic signed [COORD_BITS-1:0] goal_x,
   input  logic signed [COORD_BITS-1:0] goal_y,
   input  logic        [COORD_BITS:0]   span_x,
   input  logic        [COORD_BITS:0]   span_y,
   input  logic                         dir_x_neg,
   input  logic                         dir_y_neg,
   input  logic signed [COORD_BITS+2:0] line_error,
   output logic signed [COORD_BITS-1:0] next_x,
   output logic signed [COORD_BITS-1:0] next_y,
   output logic signed [COORD_BITS+2:0] next_error,
   output step_flags_type               flags
);

   localparam int EW = COORD_BITS + 3;

   logic signed [EW:0] e2;
   logic signed [EW:0] sx_e;
   logic signed [EW:0] sy_e;
   logic               take_x;
   logic               take_y;

   // Doubled error against the spans, one bit wider so nothing wraps
   assign e2     = {line_error, 1'b0};
   assign sx_e   = $signed((EW + 1)'(span_x));
   assign sy_e   = $signed((EW + 1)'(span_y));
   assign take_x = (e2 >= -sy_e);
   assign take_y = !take_x && (e2 <= sx_e);

   // One axis moves per cell
   always_comb begin
      next_x     = cur_x;
      next_y     = cur_y;
      next_error = line_error;
      if (take_x) begin
         next_error = line_error - $signed(EW'(span_y));
         next_x     = dir_x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
      end else if (take_y) begin
         next_error = line_error + $signed(EW'(span_x));
         next_y     = dir_y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
      end
   end

   assign flags.at_goal = (cur_x == goal_x) && (cur_y == goal_y);
   assign flags.take_x  = take_x;
   assign flags.take_y  = take_y;

endmodule

// ===== rtl/core/line_stepping_agent_motion_top.sv =====
// Moves one agent over a grid along a 4-connected Bresenham line. Each
// request (tick, dispatch or return, in req_tuser) yields exactly one
// response with position, status and flags. The block handles one request
// at a time: req_tready is high only while the sequencer is idle. For a
// dispatch, a return or an ignored request the sequencer passes from its
// exec state to its finish state, which registers the response, and then
// returns to idle to take the next request. For a tick on a moving agent
// the sequencer walks up to speed cells between its exec and finish states:
// the single step unit walks one cell per cycle, and the walk ends on
// arrival or when speed cells are walked. A response held back by
// rsp_tready holds the sequencer in its finish state. A new request is
// accepted while the last response still waits on rsp_tready. Registers are
// written over the csr channel, which is always ready, and should only be
// written while idle.
module line_stepping_agent_motion_top
   import lsam_pkg::*;
#(
   parameter int COORD_BITS = LSAM_COORD_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [15:0] dest_x, [31:16] dest_y
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [1:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [15:0] pos_x, [31:16] pos_y, [33:32] agent_status, [34] moving,
   // [35] updated, [39:36] zero
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CW = COORD_BITS;
   localparam int SW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 3;

   seq_state_type          state_ff, state_in;
   logic [1:0]             kind_ff, kind_in;
   logic signed [CW-1:0]   dest_x_ff, dest_x_in;
   logic signed [CW-1:0]   dest_y_ff, dest_y_in;
   logic signed [CW-1:0]   cur_x_ff, cur_x_in;
   logic signed [CW-1:0]   cur_y_ff, cur_y_in;
   logic signed [CW-1:0]   goal_x_ff, goal_x_in;
   logic signed [CW-1:0]   goal_y_ff, goal_y_in;
   logic [SW-1:0]          span_x_ff, span_x_in;
   logic [SW-1:0]          span_y_ff, span_y_in;
   logic                   dir_x_neg_ff, dir_x_neg_in;
   logic                   dir_y_neg_ff, dir_y_neg_in;
   logic signed [EW-1:0]   error_ff, error_in;
   agent_status_type       status_ff, status_in;
   logic                   travel_ff, travel_in;
   logic                   upd_ff, upd_in;
   logic [SPEED_BITS-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [SPEED_BITS-1:0]  speed_ff;
   logic signed [FIELD_BITS-1:0] base_x_ff;
   logic signed [FIELD_BITS-1:0] base_y_ff;

   logic signed [CW-1:0]   target_x;
   logic signed [CW-1:0]   target_y;
   logic [SW-1:0]          set_span_x;
   logic [SW-1:0]          set_span_y;
   logic signed [EW-1:0]   set_error;
   setup_flags_type        set_flags;
   logic signed [CW-1:0]   step_x;
   logic signed [CW-1:0]   step_y;
   logic signed [EW-1:0]   step_error;
   step_flags_type         step_flags;
   logic                   req_accept;

   assign req_tready = (state_ff == SEQ_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_BITS'(1);
         base_x_ff <= '0;
         base_y_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED:  speed_ff  <= csr_data[SPEED_BITS-1:0];
            CSR_BASE_X: base_x_ff <= csr_data;
            CSR_BASE_Y: base_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Target of a new line: request destination or home base
   assign target_x = (kind_ff == REQ_DISPATCH) ? dest_x_ff : CW'(base_x_ff);
   assign target_y = (kind_ff == REQ_DISPATCH) ? dest_y_ff : CW'(base_y_ff);

   lsam_line_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .target_x   (target_x),
      .target_y   (target_y),
      .span_x     (set_span_x),
      .span_y     (set_span_y),
      .line_error (set_error),
      .flags      (set_flags)
   );

   lsam_step_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .goal_x     (goal_x_ff),
      .goal_y     (goal_y_ff),
      .span_x     (span_x_ff),
      .span_y     (span_y_ff),
      .dir_x_neg  (dir_x_neg_ff),
      .dir_y_neg  (dir_y_neg_ff),
      .line_error (error_ff),
      .next_x     (step_x),
      .next_y     (step_y),
      .next_error (step_error),
      .flags      (step_flags)
   );

   // Sequencer state and agent state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         span_x_ff    <= '0;
         span_y_ff    <= '0;
         dir_x_neg_ff <= 1'b0;
         dir_y_neg_ff <= 1'b0;
         error_ff     <= '0;
         status_ff    <= ST_IDLE;
         travel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         dir_x_neg_ff <= dir_x_neg_in;
         dir_y_neg_ff <= dir_y_neg_in;
         error_ff     <= error_in;
         status_ff    <= status_in;
         travel_ff    <= travel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      dest_x_ff   <= dest_x_in;
      dest_y_ff   <= dest_y_in;
      upd_ff      <= upd_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      dest_x_in    = dest_x_ff;
      dest_y_in    = dest_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      dir_x_neg_in = dir_x_neg_ff;
      dir_y_neg_in = dir_y_neg_ff;
      error_in     = error_ff;
      status_in    = status_ff;
      travel_in    = travel_ff;
      upd_in       = upd_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_accept) begin
               kind_in   = req_tuser;
               dest_x_in = CW'($signed(req_tdata[15:0]));
               dest_y_in = CW'($signed(req_tdata[31:16]));
               state_in  = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            upd_in   = 1'b0;
            state_in = SEQ_FINISH;
            unique case (kind_ff)
               REQ_TICK: begin
                  if (status_ff == ST_ENROUTE || status_ff == ST_RETURNING) begin
                     travel_in = 1'b1;
                     upd_in    = 1'b1;
                     count_in  = '0;
                     state_in  = SEQ_WALK;
                  end
               end
               REQ_DISPATCH, REQ_RETURN: begin
                  if (kind_ff == REQ_DISPATCH || status_ff != ST_IDLE) begin
                     if (kind_ff == REQ_RETURN) begin
                        status_in = ST_RETURNING;
                     end else if (status_ff == ST_IDLE) begin
                        status_in = ST_ENROUTE;
                     end
                     // a target on the current cell keeps the old line
                     if (!set_flags.same_pos) begin
                        goal_x_in    = target_x;
                        goal_y_in    = target_y;
                        span_x_in    = set_span_x;
                        span_y_in    = set_span_y;
                        dir_x_neg_in = set_flags.dir_x_neg;
                        dir_y_neg_in = set_flags.dir_y_neg;
                        error_in     = set_error;
                        travel_in    = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         SEQ_WALK: begin
            if (step_flags.at_goal || count_ff == speed_ff) begin
               if (step_flags.at_goal) begin
                  travel_in = 1'b0;
                  if (status_ff == ST_ENROUTE) begin
                     status_in = ST_ONSCENE;
                  end else if (status_ff == ST_RETURNING) begin
                     status_in = ST_IDLE;
                  end
               end
               state_in = SEQ_FINISH;
            end else begin
               cur_x_in = step_x;
               cur_y_in = step_y;
               error_in = step_error;
               count_in = count_ff + SPEED_BITS'(1);
            end
         end
         SEQ_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {4'b0, upd_ff, travel_ff, status_ff,
                               FIELD_BITS'(cur_y_ff), FIELD_BITS'(cur_x_ff)};
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/lsam_checker.sv =====
module lsam_checker
   import lsam_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [1:0] rsp_status;
   logic       rsp_moving;
   logic       rsp_updated;

   assign rsp_status  = rsp_tdata[33:32];
   assign rsp_moving  = rsp_tdata[34];
   assign rsp_updated = rsp_tdata[35];

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // One request at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // An idle agent never reports travel
   a_idle_still: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == ST_IDLE |-> !rsp_moving)
      else $error("idle agent reports moving");

   // After a stepping tick, travel matches whether the goal was reached
   a_tick_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_updated &&
      (rsp_status == ST_ENROUTE || rsp_status == ST_RETURNING) |-> rsp_moving)
      else $error("tick short of goal cleared moving");

   a_tick_arrived: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_updated && rsp_status == ST_ONSCENE |-> !rsp_moving)
      else $error("arrival left moving set");

endmodule

bind line_stepping_agent_motion_top lsam_checker u_lsam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
